@@ hw/rtl/phtc_pkg.sv @@
// Shared types and constants for the proof-of-work hash target check.
// No dependencies; used by every module of the block.
package phtc_pkg;

  // Compact format fields
  localparam int unsigned CompactWidth = 32;
  localparam int unsigned LimitWidth   = 30;
  localparam int unsigned MantWidth    = 23;
  localparam int unsigned ExpWidth     = 8;
  localparam int unsigned WordWidth    = 64;
  localparam int unsigned SigWidth     = 3;   // word index within the hash, up to 8 words
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned OutDataWidth = 8;

  // Largest exponent that still fits a 288-bit target
  localparam logic [ExpWidth-1:0] MaxExp  = 8'd35;
  // Exponent at which the mantissa sits unshifted
  localparam logic [ExpWidth-1:0] BaseExp = 8'd3;

  // Configuration register indexes
  typedef enum logic {
    REG_TARGET = 1'b0,
    REG_LIMIT  = 1'b1
  } reg_idx_e;

  // Running comparison of hash against target
  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  // Result codes
  typedef enum logic [StatusWidth-1:0] {
    STATUS_PASS    = 2'd0,
    STATUS_ABOVE   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  // Configuration register contents
  typedef struct packed {
    logic [CompactWidth-1:0] target_compact;
    logic [LimitWidth-1:0]   limit_compact;
  } cfg_t;

  localparam logic [CompactWidth-1:0] TargetReset = 32'h1d00ffff;
  localparam logic [LimitWidth-1:0]   LimitReset  = 30'h1d00ffff;

endpackage

@@ hw/rtl/phtc_cfg_regs.sv @@
// Configuration registers of the hash target check: target and limit compact values.
// Depends on phtc_pkg.
module phtc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [phtc_pkg::CompactWidth-1:0] cfg_data_i,
  output phtc_pkg::cfg_t                    cfg_o
);

  phtc_pkg::cfg_t cfg_q;

  // Write-only registers, one index each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_compact <= phtc_pkg::TargetReset;
      cfg_q.limit_compact  <= phtc_pkg::LimitReset;
    end else if (cfg_we_i) begin
      case (phtc_pkg::reg_idx_e'(cfg_addr_i))
        phtc_pkg::REG_TARGET: cfg_q.target_compact <= cfg_data_i;
        phtc_pkg::REG_LIMIT:  cfg_q.limit_compact  <= cfg_data_i[phtc_pkg::LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/phtc_tgt_word.sv @@
// Decodes one 64-bit word of the 288-bit target from the compact target value.
// Depends on phtc_pkg.
module phtc_tgt_word (
  input  logic [phtc_pkg::CompactWidth-1:0] compact_i,
  input  logic [phtc_pkg::SigWidth-1:0]     sig_i,     // word index, 0 = least significant
  output logic [phtc_pkg::WordWidth-1:0]    word_o
);

  logic [phtc_pkg::ExpWidth-1:0]  exp_w;
  logic [phtc_pkg::MantWidth-1:0] mant;
  logic                           bad;
  logic signed [6:0]              db;    // byte shift of the mantissa relative to this word
  logic [1:0]                     neg_db;

  assign exp_w = compact_i[31:24];
  assign mant  = compact_i[phtc_pkg::MantWidth-1:0];
  assign bad   = (mant == '0) || compact_i[23] || (exp_w > phtc_pkg::MaxExp);

  // db = exp - 3 - 8 * sig, in bytes; exp is at most 35 where it matters
  assign db     = $signed({1'b0, exp_w[5:0]}) - 7'sd3 - $signed({1'b0, sig_i, 3'b000});
  assign neg_db = 2'(-db);

  always_comb begin
    word_o = '0;
    if (!bad) begin
      if (db >= 7'sd0 && db <= 7'sd7) begin
        word_o = 64'(mant) << {db[2:0], 3'b000};
      end else if (db >= -7'sd3 && db < 7'sd0) begin
        word_o = 64'(mant) >> {neg_db, 3'b000};
      end
    end
  end

endmodule

@@ hw/rtl/phtc_tgt_valid.sv @@
// Validity of the target: both compact values well formed and target at most limit.
// Depends on phtc_pkg.
module phtc_tgt_valid (
  input  phtc_pkg::cfg_t cfg_i,
  output logic           valid_o
);

  localparam int unsigned AlignWidth = phtc_pkg::MantWidth + 16;

  typedef struct packed {
    logic                           ok;
    logic [5:0]                     ee;  // exponent, raised to 3 for small values
    logic [phtc_pkg::MantWidth-1:0] v;   // mantissa after right shift for small exponents
  } norm_t;

  // Small exponents shift the mantissa right and are then treated as exponent 3
  function automatic norm_t normalize(input logic [phtc_pkg::CompactWidth-1:0] c);
    norm_t                          r;
    logic [phtc_pkg::ExpWidth-1:0]  e;
    logic [phtc_pkg::MantWidth-1:0] m;
    logic [1:0]                     rs;
    e    = c[31:24];
    m    = c[phtc_pkg::MantWidth-1:0];
    rs   = 2'(phtc_pkg::BaseExp - e);
    r.ee = 6'(e);
    r.v  = m;
    if (e < phtc_pkg::BaseExp) begin
      r.v  = m >> {rs, 3'b000};
      r.ee = 6'(phtc_pkg::BaseExp);
    end
    r.ok = (m != '0) && !c[23] && (e <= phtc_pkg::MaxExp) && (r.v != '0);
    return r;
  endfunction

  norm_t                 tn, ln;
  logic [6:0]            et, el;
  logic [1:0]            dt, dl;
  logic [AlignWidth-1:0] at, al;
  logic                  le;

  assign tn = normalize(cfg_i.target_compact);
  assign ln = normalize({2'b00, cfg_i.limit_compact});
  assign et = {1'b0, tn.ee};
  assign el = {1'b0, ln.ee};
  assign dt = 2'(et - el);
  assign dl = 2'(el - et);
  assign at = AlignWidth'(tn.v) << {dt, 3'b000};
  assign al = AlignWidth'(ln.v) << {dl, 3'b000};

  // Three bytes of exponent outweigh any 23-bit mantissa; closer ones are aligned
  always_comb begin
    if (et > el + 7'd2) begin
      le = 1'b0;
    end else if (el > et + 7'd2) begin
      le = 1'b1;
    end else if (et >= el) begin
      le = at <= AlignWidth'(ln.v);
    end else begin
      le = AlignWidth'(tn.v) <= al;
    end
  end

  assign valid_o = tn.ok && ln.ok && le;

endmodule

@@ hw/rtl/pow_hash_target_check_unit.sv @@
// Top level of the proof-of-work hash target check.
// Depends on phtc_pkg, phtc_cfg_regs, phtc_tgt_word and phtc_tgt_valid.
//
// Usage:
//  - Input stream s_axis: one 64-bit hash word per beat, most significant word first;
//    every HASH_WORDS beats form one hash. No tlast: the block counts words itself.
//  - Output stream m_axis: one status beat per hash (tdata[1:0]): 0 hash at or below
//    target, 1 hash above target, 2 target invalid.
//  - Config port: cfg_we_i with cfg_addr_i 0 writes the compact target, 1 the compact
//    limit (low 30 bits). Write only while no hash is in progress.
//  - Throughput: one word per cycle unless a final word stalls. Each word passes an
//    input register, is compared with the matching target word in the next cycle,
//    and the status of the last word then moves on into the output register.
//  - The output register is the only place a status waits; while it is full and
//    m_axis_tready_i is low, non-final words still stream through, and a final word
//    stalls in the input register, which then holds s_axis_tready_o low.
//  - Reset empties both registers, restarts the word count at the first word and
//    loads both compact registers with 0x1d00ffff.
module pow_hash_target_check_unit #(
  parameter int unsigned HASH_WORDS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream; tdata: hash_word[63:0]
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [phtc_pkg::WordWidth-1:0]    s_axis_tdata_i,
  // Output stream; tdata: status[1:0], zeros above
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [phtc_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [phtc_pkg::CompactWidth-1:0] cfg_data_i
);

  localparam int unsigned CntWidth = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
  localparam logic [CntWidth-1:0] LastCnt = CntWidth'(HASH_WORDS - 1);
  localparam logic [phtc_pkg::SigWidth-1:0] TopSig = phtc_pkg::SigWidth'(HASH_WORDS - 1);

  phtc_pkg::cfg_t cfg;
  logic [phtc_pkg::WordWidth-1:0] tgt_word;
  logic tgt_ok;

  // Input register stage
  logic                              in_vld_q;
  logic [phtc_pkg::WordWidth-1:0]    in_word_q;
  logic [phtc_pkg::SigWidth-1:0]     in_sig_q;
  logic                              in_last_q;
  logic [CntWidth-1:0]               cnt_q;

  // Compare state and output register
  phtc_pkg::cmp_e    cmp_q, cmp_d;
  logic              out_vld_q;
  phtc_pkg::status_e status_q, status_d;

  logic s_take, advance;

  phtc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  phtc_tgt_word u_tgt_word (
    .compact_i (cfg.target_compact),
    .sig_i     (in_sig_q),
    .word_o    (tgt_word)
  );

  phtc_tgt_valid u_tgt_valid (
    .cfg_i   (cfg),
    .valid_o (tgt_ok)
  );

  // A non-final word never needs the output register
  assign advance         = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  // Word counter and input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (s_take) begin
        in_vld_q <= 1'b1;
        cnt_q    <= (cnt_q == LastCnt) ? '0 : cnt_q + 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_word_q <= s_axis_tdata_i;
      in_sig_q  <= TopSig - phtc_pkg::SigWidth'(cnt_q);
      in_last_q <= (cnt_q == LastCnt);
    end
  end

  // First differing word decides the comparison
  always_comb begin
    cmp_d = cmp_q;
    if (cmp_q == phtc_pkg::CMP_EQ) begin
      if (in_word_q < tgt_word) begin
        cmp_d = phtc_pkg::CMP_LT;
      end else if (in_word_q > tgt_word) begin
        cmp_d = phtc_pkg::CMP_GT;
      end
    end
  end

  // Status of the finished hash
  always_comb begin
    if (!tgt_ok) begin
      status_d = phtc_pkg::STATUS_INVALID;
    end else if (cmp_d == phtc_pkg::CMP_GT) begin
      status_d = phtc_pkg::STATUS_ABOVE;
    end else begin
      status_d = phtc_pkg::STATUS_PASS;
    end
  end

  // Compare state and output register; a new status wins over a drained one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q     <= phtc_pkg::CMP_EQ;
      out_vld_q <= 1'b0;
    end else begin
      if (advance && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        if (in_last_q) begin
          cmp_q <= phtc_pkg::CMP_EQ;
        end else begin
          cmp_q <= cmp_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(phtc_pkg::OutDataWidth - phtc_pkg::StatusWidth){1'b0}}, status_q};

endmodule

@@ sim/tb_pow_hash_target_check_unit.sv @@
// Self-checking testbench for pow_hash_target_check_unit: streams 64-bit hash words,
// predicts each status beat from its own target decoder and compares beat by beat.
// Depends on phtc_pkg and the RTL of pow_hash_target_check_unit.
module tb_pow_hash_target_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HashWords   = 4;
  localparam int unsigned TgtWords    = 5;   // 320-bit decode, covers the 288-bit target
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseHashes = 40;

  typedef logic [TgtWords*phtc_pkg::WordWidth-1:0] wide_t;
  typedef logic [phtc_pkg::WordWidth-1:0] hash_words_t [HashWords];

  // DUT signals, inputs driven to known values from time zero
  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [phtc_pkg::WordWidth-1:0]    s_axis_tdata_i  = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [phtc_pkg::OutDataWidth-1:0] m_axis_tdata_o;
  logic                              cfg_we_i        = 1'b0;
  logic                              cfg_addr_i      = phtc_pkg::REG_TARGET;
  logic [phtc_pkg::CompactWidth-1:0] cfg_data_i      = '0;

  // Predictor state: register copies and running hash comparison
  logic [phtc_pkg::CompactWidth-1:0] target_reg  = phtc_pkg::TargetReset;
  logic [phtc_pkg::LimitWidth-1:0]   limit_reg   = phtc_pkg::LimitReset;
  int unsigned                       word_idx    = 0;
  phtc_pkg::cmp_e                    running_cmp = phtc_pkg::CMP_EQ;
  phtc_pkg::status_e                 pending_status [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          send_quiet     = 1'b0;
  bit          recv_quiet     = 1'b0;

  pow_hash_target_check_unit #(
    .HASH_WORDS(HashWords)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // hash_word[63:0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // status[1:0], zeros above
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Expand a compact value; returns 0 when the value is not a usable target
  function automatic logic decode_compact(input logic [phtc_pkg::CompactWidth-1:0] c,
                                          output wide_t v);
    logic [phtc_pkg::ExpWidth-1:0]  e;
    logic [phtc_pkg::MantWidth-1:0] m;
    e = c[phtc_pkg::CompactWidth-1 -: phtc_pkg::ExpWidth];
    m = c[phtc_pkg::MantWidth-1:0];
    v = '0;
    if (m == '0 || c[phtc_pkg::MantWidth] || e > phtc_pkg::MaxExp) return 1'b0;
    if (e <= phtc_pkg::BaseExp) begin
      v = wide_t'(m) >> (8 * (phtc_pkg::BaseExp - e));
      return v != '0;
    end
    v = wide_t'(m) << (8 * (e - phtc_pkg::BaseExp));
    return 1'b1;
  endfunction

  // Target word that hash word i (most significant first) is compared with
  function automatic logic [phtc_pkg::WordWidth-1:0] target_word(input wide_t tgt,
                                                                 input int i);
    int sig;
    sig = HashWords - 1 - i;
    if (sig >= 0 && sig < TgtWords) return tgt[sig*phtc_pkg::WordWidth +: phtc_pkg::WordWidth];
    return '0;
  endfunction

  // Append one expected status beat
  task automatic queue_status(input phtc_pkg::status_e st);
    pending_status = {pending_status, st};
  endtask

  // Advance the predictor by one accepted hash word
  task automatic predict_hash_word(input logic [phtc_pkg::WordWidth-1:0] word);
    wide_t                          tgt, lim;
    logic                           tgt_ok, lim_ok;
    logic [phtc_pkg::WordWidth-1:0] tw;
    tgt_ok = decode_compact(target_reg, tgt);
    tw = target_word(tgt, word_idx);
    if (running_cmp == phtc_pkg::CMP_EQ) begin
      if (word < tw) running_cmp = phtc_pkg::CMP_LT;
      else if (word > tw) running_cmp = phtc_pkg::CMP_GT;
    end
    word_idx++;
    if (word_idx == HashWords) begin
      lim_ok = decode_compact({2'b00, limit_reg}, lim);
      if (!(tgt_ok && lim_ok && tgt <= lim)) queue_status(phtc_pkg::STATUS_INVALID);
      else if (running_cmp == phtc_pkg::CMP_GT) queue_status(phtc_pkg::STATUS_ABOVE);
      else queue_status(phtc_pkg::STATUS_PASS);
      word_idx    = 0;
      running_cmp = phtc_pkg::CMP_EQ;
    end
  endtask

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [phtc_pkg::WordWidth-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One input beat; valid stays high into the next beat when no gap is drawn
  task automatic send_word(input logic [phtc_pkg::WordWidth-1:0] word);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_hash_word(word);
  endtask

  task automatic send_hash(input hash_words_t h);
    for (int i = 0; i < HashWords; i++) send_word(h[i]);
  endtask

  // Stop input, wait for every status, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers back to back while the block is idle
  task automatic set_config(input logic [phtc_pkg::CompactWidth-1:0] tgt_c,
                            input logic [phtc_pkg::CompactWidth-1:0] lim_c);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= phtc_pkg::REG_TARGET;
    cfg_data_i <= tgt_c;
    @(posedge clk_i);
    target_reg = tgt_c;
    cfg_addr_i <= phtc_pkg::REG_LIMIT;
    cfg_data_i <= lim_c;
    @(posedge clk_i);
    limit_reg = lim_c[phtc_pkg::LimitWidth-1:0];
    cfg_we_i <= 1'b0;
  endtask

  // Hash close to the current target (equal prefix, then a nudged word) or fully random
  function automatic void build_hash(output hash_words_t h);
    wide_t tgt;
    int    mode, prefix;
    void'(decode_compact(target_reg, tgt));
    mode = $urandom_range(0, 9);
    prefix = $urandom_range(0, HashWords);
    for (int i = 0; i < HashWords; i++) begin
      if (mode >= 8) h[i] = rand_word();
      else if (mode == 7 || i < prefix) h[i] = target_word(tgt, i);
      else if (i == prefix) begin
        case ($urandom_range(0, 3))
          0:       h[i] = target_word(tgt, i) - 1;
          1:       h[i] = target_word(tgt, i) + 1;
          2:       h[i] = target_word(tgt, i) ^ (64'd1 << $urandom_range(0, 63));
          default: h[i] = rand_word();
        endcase
      end else h[i] = rand_word();
    end
  endfunction

  // Status checker
  initial begin
    phtc_pkg::status_e want;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      int stall;
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("unexpected status beat: tdata=%0h", m_axis_tdata_o);
      end else begin
        want = pending_status.pop_front();
        if (m_axis_tdata_o !== phtc_pkg::OutDataWidth'(want)) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("status mismatch: expected %0h, got %0h",
                     phtc_pkg::OutDataWidth'(want), m_axis_tdata_o);
        end
      end
    end
  end

  // Reset values: hash equal to the target passes, all-ones hash is above
  task automatic test_reset_target();
    hash_words_t h;
    wide_t       tgt;
    void'(decode_compact(target_reg, tgt));
    for (int i = 0; i < HashWords; i++) h[i] = target_word(tgt, i);
    send_hash(h);
    for (int i = 0; i < HashWords; i++) h[i] = '1;
    send_hash(h);
  endtask

  // Ways in which a target or limit can be rejected
  task automatic test_invalid_compact();
    hash_words_t h;
    logic [phtc_pkg::CompactWidth-1:0] cases [6][2];
    cases = '{'{32'h1d000000, 32'h1d00ffff},   // zero mantissa, all-zero hash below
              '{32'h1d80ffff, 32'h1d00ffff},   // sign bit set
              '{32'h2400ffff, 32'h1d00ffff},   // exponent past 288 bits
              '{32'h0100ffff, 32'h1d00ffff},   // small exponent shifts mantissa to zero
              '{32'h1e00ffff, 32'h1d00ffff},   // target above limit
              '{32'h1d00ffff, 32'h2400ffff}};  // limit exponent out of range
    for (int c = 0; c < 6; c++) begin
      set_config(cases[c][0], cases[c][1]);
      for (int i = 0; i < HashWords; i++) h[i] = (c == 0) ? '0 : rand_word();
      send_hash(h);
    end
  endtask

  // Random hashes across several register settings and idle patterns
  task automatic test_random_hashes();
    hash_words_t                       h;
    logic [phtc_pkg::CompactWidth-1:0] tgt_c, lim_c;
    logic [phtc_pkg::ExpWidth-1:0]     e, e_lim;
    logic [phtc_pkg::MantWidth-1:0]    m;
    for (int p = 0; p < RandPhases; p++) begin
      e     = phtc_pkg::ExpWidth'($urandom_range(1, 35));
      m     = phtc_pkg::MantWidth'($urandom_range(1, 23'h7fffff));
      tgt_c = {e, 1'b0, m};
      e_lim = phtc_pkg::ExpWidth'($urandom_range(e, 35));
      case ($urandom_range(0, 3))
        0:       lim_c = tgt_c;
        1:       lim_c = {e_lim, 1'b0, 23'h7fffff};
        2:       lim_c = $urandom;
        default: lim_c = {e - 8'd1, 1'b0, m};
      endcase
      case (p)
        0: begin
          tgt_c = phtc_pkg::TargetReset;
          lim_c = 32'(phtc_pkg::LimitReset);
        end
        1:       begin tgt_c = 32'h237fffff; lim_c = 32'hc37fffff;    end
        2:       begin tgt_c = 32'h03000001; lim_c = 32'h1d00ffff;    end
        3:       begin tgt_c = 32'h00000000; lim_c = 32'h00000000;    end
        4:       begin tgt_c = 32'hffffffff; lim_c = 32'hffffffff;    end
        9:       tgt_c = $urandom;
        default: ;
      endcase
      lim_c[31:30] = 2'($urandom_range(0, 3));
      set_config(tgt_c, lim_c);
      send_quiet = p[0];
      recv_quiet = p[1];
      for (int n = 0; n < PhaseHashes; n++) begin
        build_hash(h);
        send_hash(h);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_target();
    test_invalid_compact();
    test_random_hashes();
    drain_results();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ pow_hash_target_check_unit.f @@
hw/rtl/phtc_pkg.sv
hw/rtl/phtc_cfg_regs.sv
hw/rtl/phtc_tgt_word.sv
hw/rtl/phtc_tgt_valid.sv
hw/rtl/pow_hash_target_check_unit.sv
sim/tb_pow_hash_target_check_unit.sv
